// ===== sv/pcrg_pkg.sv =====
// ----------------------------------------------------------------------------
// pcrg_pkg
// shared constants, register codes and types of the pinhole ray generator
// ----------------------------------------------------------------------------
package pcrg_pkg;

	localparam int PIXEL_INDEX_BITS_DEF = 12;
	localparam int FRACTION_BITS_DEF    = 16;

	localparam int ENTRY_W   = 16;  // Q4.12 matrix entry
	localparam int CANVAS_W  = 33;  // saturated canvas coordinate, Q.(F+1)
	localparam int MAG_W     = 49;  // magnitude of a raw direction component
	localparam int NORM_W    = 31;  // normalised component magnitude
	localparam int SUM_W     = 64;  // sum of squares
	localparam int LEN_W     = 32;  // integer square root
	localparam int QUO_W     = 31;  // quotient, at most 2^30
	localparam int NUM_W     = 62;  // dividend
	localparam int OUT_W     = 32;
	localparam int FIFO_DEPTH = 4;

	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_PITCH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_HEIGHT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_ROW0    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_ROW1    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_ROW2    = 3'd5;

	localparam logic [63:0] INV_ROW0_RST = 64'h1000_0000_0000_0000;
	localparam logic [63:0] INV_ROW1_RST = 64'h0000_1000_0000_0000;
	localparam logic [63:0] INV_ROW2_RST = 64'h0000_0000_1000_0000;

	typedef struct packed {
		logic [30:0]        pixel_pitch;
		logic signed [31:0] half_width_world;
		logic signed [31:0] half_height_world;
		logic [2:0][63:0]   inv_row;
	} pcrg_cfg_t;

	// raw direction, one sign and magnitude per axis
	typedef struct packed {
		logic [2:0]             neg;
		logic [2:0][MAG_W-1:0]  mag;
	} pcrg_dir_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pcrg_qstat_t;

	function automatic logic signed [ENTRY_W-1:0] entry(input logic [63:0] row,
		input int k);
		return row[(63 - ENTRY_W*k) -: ENTRY_W];
	endfunction

endpackage

// ===== sv/pinhole_camera_ray_generator.sv =====
// ----------------------------------------------------------------------------
// pinhole_camera_ray_generator
// primary ray of a pixel centre through an affine inverse camera transform
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while the output does not stall, set
//   by the pipelined square root and the three pipelined dividers in the
//   back part (one bit per stage)
// the four-entry queue lets the front keep taking pixels while output stalls
// reset clears all valid state and loads the identity matrix, zero pitch
// and zero half extents; configuration writes are taken in any cycle
module pinhole_camera_ray_generator #(
	parameter int PIXEL_INDEX_BITS = pcrg_pkg::PIXEL_INDEX_BITS_DEF,
	parameter int FRACTION_BITS    = pcrg_pkg::FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// input stream: pixel_col, pixel_row, zero padding
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [((2*PIXEL_INDEX_BITS+7)/8)*8-1:0] s_axis_tdata,
	// output stream: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [191:0] m_axis_tdata,
	// degenerate
	output logic         m_axis_tuser,
	// register writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pcrg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]                      cfg_data
);

	pcrg_pkg::pcrg_cfg_t   cfg_q;
	pcrg_pkg::pcrg_qstat_t q_stat;
	pcrg_pkg::pcrg_dir_t   push_data, pop_data;
	logic push, pop;

	// register file, always ready; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_pitch       <= '0;
			cfg_q.half_width_world  <= '0;
			cfg_q.half_height_world <= '0;
			cfg_q.inv_row[0]        <= pcrg_pkg::INV_ROW0_RST;
			cfg_q.inv_row[1]        <= pcrg_pkg::INV_ROW1_RST;
			cfg_q.inv_row[2]        <= pcrg_pkg::INV_ROW2_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pcrg_pkg::REG_PIXEL_PITCH: cfg_q.pixel_pitch       <= cfg_data[30:0];
				pcrg_pkg::REG_HALF_WIDTH:  cfg_q.half_width_world  <= cfg_data[31:0];
				pcrg_pkg::REG_HALF_HEIGHT: cfg_q.half_height_world <= cfg_data[31:0];
				pcrg_pkg::REG_INV_ROW0:    cfg_q.inv_row[0]        <= cfg_data;
				pcrg_pkg::REG_INV_ROW1:    cfg_q.inv_row[1]        <= cfg_data;
				pcrg_pkg::REG_INV_ROW2:    cfg_q.inv_row[2]        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: canvas point and raw direction
	pcrg_front #(
		.PIXEL_INDEX_BITS(PIXEL_INDEX_BITS),
		.FRACTION_BITS   (FRACTION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.pixel_col(s_axis_tdata[PIXEL_INDEX_BITS-1:0]),
		.pixel_row(s_axis_tdata[2*PIXEL_INDEX_BITS-1:PIXEL_INDEX_BITS]),
		.q_stat   (q_stat),
		.push     (push),
		.push_data(push_data)
	);

	// decoupling queue
	pcrg_fifo #(
		.WIDTH($bits(pcrg_pkg::pcrg_dir_t)),
		.DEPTH(pcrg_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (push_data),
		.pop   (pop),
		.dout  (pop_data),
		.stat  (q_stat)
	);

	// back: normalisation and output register
	pcrg_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (!q_stat.empty),
		.pop           (pop),
		.in_data       (pop_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_data      (m_axis_tdata),
		.out_degenerate(m_axis_tuser)
	);

	// a degenerate ray carries a zero direction
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[191:96] == '0)
		else $error("degenerate ray with non-zero direction");

	// the x component of the unit direction stays within one
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[127:96]) <= 32'sd1073741824)
			&& ($signed(m_axis_tdata[127:96]) >= -32'sd1073741824))
		else $error("dir_x out of range");

	// the front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue overflow");

	// the back only pops a queue holding data
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue underflow");

endmodule

// ===== sv/pcrg_front.sv =====
// ----------------------------------------------------------------------------
// pcrg_front
// canvas position and raw direction of a pixel, four stages
// ----------------------------------------------------------------------------
module pcrg_front #(
	parameter int PIXEL_INDEX_BITS = pcrg_pkg::PIXEL_INDEX_BITS_DEF,
	parameter int FRACTION_BITS    = pcrg_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pcrg_pkg::pcrg_cfg_t         cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [PIXEL_INDEX_BITS-1:0] pixel_col,
	input  logic [PIXEL_INDEX_BITS-1:0] pixel_row,
	input  pcrg_pkg::pcrg_qstat_t       q_stat,
	output logic                        push,
	output pcrg_pkg::pcrg_dir_t         push_data
);

	localparam int OFF_W  = PIXEL_INDEX_BITS + 32;
	localparam int W_W    = OFF_W + 2;
	localparam int PROD_W = pcrg_pkg::ENTRY_W + pcrg_pkg::CANVAS_W;
	localparam int D_W    = pcrg_pkg::MAG_W + 2;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [OFF_W-1:0] off_x_s1, off_y_s1;
	logic signed [pcrg_pkg::CANVAS_W-1:0] wx_s2, wy_s2;
	logic signed [PROD_W-1:0] px_s3 [3];
	logic signed [PROD_W-1:0] py_s3 [3];
	logic signed [pcrg_pkg::ENTRY_W-1:0] ez_s3 [3];
	pcrg_pkg::pcrg_dir_t dir_s4;

	logic signed [W_W-1:0] wx, wy;

	assign en       = !v_s4 || !q_stat.full;
	assign in_ready = en;
	assign push     = v_s4 && !q_stat.full;
	assign push_data = dir_s4;

	function automatic logic signed [pcrg_pkg::CANVAS_W-1:0] sat(input logic signed [W_W-1:0] v);
		if (&v[W_W-1:32] || ~|v[W_W-1:32]) begin
			return v[pcrg_pkg::CANVAS_W-1:0];
		end else if (v[W_W-1]) begin
			return {1'b1, 32'h0};
		end else begin
			return {1'b0, 32'hFFFF_FFFF};
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// twice the centre offset: (2i + 1) * pitch
	always_ff @(posedge clk) begin
		if (en) begin
			off_x_s1 <= OFF_W'({pixel_col, 1'b1}) * OFF_W'(cfg.pixel_pitch);
			off_y_s1 <= OFF_W'({pixel_row, 1'b1}) * OFF_W'(cfg.pixel_pitch);
		end
	end

	assign wx = (W_W'(cfg.half_width_world) <<< 1) - $signed(W_W'(off_x_s1));
	assign wy = (W_W'(cfg.half_height_world) <<< 1) - $signed(W_W'(off_y_s1));

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s2 <= sat(wx);
			wy_s2 <= sat(wy);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				px_s3[r] <= pcrg_pkg::entry(cfg.inv_row[r], 0) * wx_s2;
				py_s3[r] <= pcrg_pkg::entry(cfg.inv_row[r], 1) * wy_s2;
				ez_s3[r] <= pcrg_pkg::entry(cfg.inv_row[r], 2);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [D_W-1:0] d;
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				d = D_W'(px_s3[r]) + D_W'(py_s3[r])
					- (D_W'(ez_s3[r]) <<< (FRACTION_BITS + 1));
				dir_s4.neg[r] <= d[D_W-1];
				dir_s4.mag[r] <= d[D_W-1] ? pcrg_pkg::MAG_W'(-d) : pcrg_pkg::MAG_W'(d);
			end
		end
	end

endmodule

// ===== sv/pcrg_fifo.sv =====
// ----------------------------------------------------------------------------
// pcrg_fifo
// short queue between the front and back parts
// ----------------------------------------------------------------------------
module pcrg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pcrg_pkg::FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      din,
	input  logic                  pop,
	output logic [WIDTH-1:0]      dout,
	output pcrg_pkg::pcrg_qstat_t stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign dout       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== sv/pcrg_back.sv =====
// ----------------------------------------------------------------------------
// pcrg_back
// normalisation of the direction: scale, square root, three dividers
// ----------------------------------------------------------------------------
module pcrg_back #(
	parameter int FRACTION_BITS = pcrg_pkg::FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pcrg_pkg::pcrg_cfg_t cfg,
	input  logic                in_valid,
	output logic                pop,
	input  pcrg_pkg::pcrg_dir_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [191:0]        out_data,
	output logic                out_degenerate
);

	localparam int NORM_W = pcrg_pkg::NORM_W;
	localparam int LEN_W  = pcrg_pkg::LEN_W;
	localparam int QUO_W  = pcrg_pkg::QUO_W;
	localparam int NUM_W  = pcrg_pkg::NUM_W;
	localparam int SQ_STEPS  = LEN_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int NST = 5 + SQ_STEPS + 1 + DIV_STEPS + 1;
	localparam int N_W = $clog2(pcrg_pkg::MAG_W + 1);

	typedef struct packed {
		logic                    deg;
		logic [2:0]              neg;
		logic [2:0][NORM_W-1:0]  nm;
	} sq_carry_t;

	typedef struct packed {
		logic             deg;
		logic [2:0]       neg;
		logic [LEN_W-1:0] len;
	} dv_carry_t;

	logic en;
	logic [NST-1:0] vld_q;

	pcrg_pkg::pcrg_dir_t d_s1, d_s2;
	logic [pcrg_pkg::MAG_W-1:0] or_s1;
	logic [N_W-1:0] n_s2;
	logic deg_s2;
	sq_carry_t c_s3, c_s4, c_s5;
	logic [2:0][2*NORM_W-1:0] sq_s4;
	logic [pcrg_pkg::SUM_W-1:0] sum_s5;

	logic [35:0]      sq_rem_q  [1:SQ_STEPS];
	logic [LEN_W-1:0] sq_root_q [1:SQ_STEPS];
	logic [63:0]      sq_val_q  [1:SQ_STEPS];
	sq_carry_t        sq_c_q    [1:SQ_STEPS];

	logic [2:0][NUM_W-1:0] num_s6;
	dv_carry_t c_s6;

	logic [2:0][32:0]       dv_rem_q [1:DIV_STEPS];
	logic [2:0][NUM_W-1:0]  dv_num_q [1:DIV_STEPS];
	logic [2:0][QUO_W-1:0]  dv_quo_q [1:DIV_STEPS];
	dv_carry_t              dv_c_q   [1:DIV_STEPS];

	logic [191:0] out_data_q;
	logic         deg_q;

	assign en  = !vld_q[NST-1] || out_ready;
	assign pop = in_valid && en;
	assign out_valid      = vld_q[NST-1];
	assign out_data       = out_data_q;
	assign out_degenerate = deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// leading one of the largest magnitude
	always_ff @(posedge clk) begin
		logic [N_W-1:0] n;
		if (en) begin
			d_s1  <= in_data;
			or_s1 <= in_data.mag[0] | in_data.mag[1] | in_data.mag[2];
			n = '0;
			for (int i = 0; i < pcrg_pkg::MAG_W; i++) begin
				if (or_s1[i]) begin
					n = N_W'(i + 1);
				end
			end
			d_s2   <= d_s1;
			n_s2   <= n;
			deg_s2 <= (or_s1 == '0);
		end
	end

	// scale so that the largest magnitude has 31 bits, then square and sum
	always_ff @(posedge clk) begin
		if (en) begin
			c_s3.deg <= deg_s2;
			c_s3.neg <= d_s2.neg;
			for (int r = 0; r < 3; r++) begin
				if (n_s2 > N_W'(NORM_W)) begin
					c_s3.nm[r] <= NORM_W'(d_s2.mag[r] >> (n_s2 - N_W'(NORM_W)));
				end else begin
					c_s3.nm[r] <= NORM_W'(d_s2.mag[r] << (N_W'(NORM_W) - n_s2));
				end
				sq_s4[r] <= {{NORM_W{1'b0}}, c_s3.nm[r]} * {{NORM_W{1'b0}}, c_s3.nm[r]};
			end
			c_s4   <= c_s3;
			sum_s5 <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
			c_s5   <= c_s4;
		end
	end

	// square root, one result bit per stage
	for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
		logic [35:0]      rin, rn, tr;
		logic [LEN_W-1:0] oin;
		logic [63:0]      vin;
		sq_carry_t        cin;
		if (j == 1) begin : g_first
			assign rin = '0;
			assign oin = '0;
			assign vin = sum_s5;
			assign cin = c_s5;
		end else begin : g_next
			assign rin = sq_rem_q[j-1];
			assign oin = sq_root_q[j-1];
			assign vin = sq_val_q[j-1];
			assign cin = sq_c_q[j-1];
		end
		assign rn = {rin[33:0], vin[63:62]};
		assign tr = {2'b00, oin, 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				if (rn >= tr) begin
					sq_rem_q[j]  <= rn - tr;
					sq_root_q[j] <= {oin[LEN_W-2:0], 1'b1};
				end else begin
					sq_rem_q[j]  <= rn;
					sq_root_q[j] <= {oin[LEN_W-2:0], 1'b0};
				end
				sq_val_q[j] <= {vin[61:0], 2'b00};
				sq_c_q[j]   <= cin;
			end
		end
	end

	// dividend with half the length added for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				num_s6[r] <= NUM_W'({sq_c_q[SQ_STEPS].nm[r], 30'b0})
					+ NUM_W'(sq_root_q[SQ_STEPS] >> 1);
			end
			c_s6.deg <= sq_c_q[SQ_STEPS].deg;
			c_s6.neg <= sq_c_q[SQ_STEPS].neg;
			c_s6.len <= sq_root_q[SQ_STEPS];
		end
	end

	// restoring division, three lanes, one quotient bit per stage
	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		logic [2:0][32:0]      rin;
		logic [2:0][NUM_W-1:0] nin;
		logic [2:0][QUO_W-1:0] qin;
		dv_carry_t             cin;
		if (j == 1) begin : g_first
			for (genvar r = 0; r < 3; r++) begin : g_lane
				assign rin[r] = {2'b00, num_s6[r][NUM_W-1 -: QUO_W]};
				assign nin[r] = {num_s6[r][QUO_W-1:0], {QUO_W{1'b0}}};
				assign qin[r] = '0;
			end
			assign cin = c_s6;
		end else begin : g_next
			assign rin = dv_rem_q[j-1];
			assign nin = dv_num_q[j-1];
			assign qin = dv_quo_q[j-1];
			assign cin = dv_c_q[j-1];
		end
		always_ff @(posedge clk) begin
			logic [32:0] r2;
			if (en) begin
				for (int r = 0; r < 3; r++) begin
					r2 = {rin[r][31:0], nin[r][NUM_W-1]};
					if (r2 >= {1'b0, cin.len}) begin
						dv_rem_q[j][r] <= r2 - {1'b0, cin.len};
						dv_quo_q[j][r] <= {qin[r][QUO_W-2:0], 1'b1};
					end else begin
						dv_rem_q[j][r] <= r2;
						dv_quo_q[j][r] <= {qin[r][QUO_W-2:0], 1'b0};
					end
					dv_num_q[j][r] <= {nin[r][NUM_W-2:0], 1'b0};
				end
				dv_c_q[j] <= cin;
			end
		end
	end

	// result register: origin from the translation column, signed direction
	always_ff @(posedge clk) begin
		logic [31:0] q;
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				out_data_q[32*r +: 32] <=
					32'(pcrg_pkg::entry(cfg.inv_row[r], 3)) <<< (FRACTION_BITS - 12);
				q = {1'b0, dv_quo_q[DIV_STEPS][r]};
				if (dv_c_q[DIV_STEPS].deg) begin
					out_data_q[96 + 32*r +: 32] <= '0;
				end else if (dv_c_q[DIV_STEPS].neg[r]) begin
					out_data_q[96 + 32*r +: 32] <= -q;
				end else begin
					out_data_q[96 + 32*r +: 32] <= q;
				end
			end
			deg_q <= dv_c_q[DIV_STEPS].deg;
		end
	end

endmodule
